@@ design/mrfe_pkg.sv @@
// Package for the Manchester RF frame encoder.
// Holds operation codes, register indexes, reset values and segment counts.
// No dependencies.
`default_nettype none

package mrfe_pkg;

	localparam int CFG_INDEX_W = 4;
	localparam int DUR_W = 16;
	localparam int BITS_PER_BYTE = 8;
	localparam int SEGS_PER_BYTE = 2 * BITS_PER_BYTE;

	localparam logic OP_FRAME_START = 1'b0;
	localparam logic OP_DATA = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_PULSE = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FINISH_PULSE = 4'd3;

	localparam logic [DUR_W-1:0] HALF_BIT_RESET = 16'd1100;
	localparam logic [DUR_W-1:0] START_PULSE_RESET = 16'd2000;
	localparam logic [DUR_W-1:0] GAP_RESET = 16'd500;
	localparam logic [DUR_W-1:0] FINISH_PULSE_RESET = 16'd3000;

	localparam logic [BITS_PER_BYTE-1:0] PREAMBLE_PATTERN = 8'hFF;

endpackage

`default_nettype wire

@@ design/manchester_rf_frame_encoder_unit.sv @@
// Top level of the Manchester RF frame encoder.
// Uses mrfe_pkg for codes, register indexes and reset values.
//
// Usage: an input request (op, data_byte, last_byte) is taken on in_valid and
// in_ready. A frame-start request (op 0) expands into PREAMBLE_BYTES*16+3 line
// segments: the 0xFF preamble bytes, the start pulse high and low halves, and
// the low gap. A data request (op 1) expands into 16 half-bit segments, LSB
// first, plus the two finish pulse halves when last_byte is set. Each segment
// leaves on out_valid and out_ready as line_level and duration_us; run_last
// marks the final segment of a request.
// Timing: a request is first registered in the expansion stage; its first
// segment then enters the output register once that register is free. One
// segment is produced per cycle while the receiver takes them; the next request
// is taken in the cycle its predecessor's final segment enters the output
// register, which sets the rate.
// The configuration port takes a write every cycle (cfg_ready is always
// high); writes to an index above 3 are dropped.
// Reset clears both stages and loads the default durations. When the
// receiver stalls, the output register holds its segment and the expansion
// stage waits with it; once that stage is full, in_ready stays low.
`default_nettype none

module manchester_rf_frame_encoder_unit #(
	parameter int PREAMBLE_BYTES = 3
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            op,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            last_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 line_level,
	output logic [mrfe_pkg::DUR_W-1:0]           duration_us,
	output logic                                 run_last,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [mrfe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mrfe_pkg::DUR_W-1:0]       cfg_data
);

	localparam int PRE_SEGS = PREAMBLE_BYTES * mrfe_pkg::SEGS_PER_BYTE;
	localparam int FRAME_SEGS = PRE_SEGS + 3;
	localparam int CNT_W = $clog2(FRAME_SEGS);
	localparam logic [CNT_W-1:0] PRE_END = CNT_W'(PRE_SEGS);
	localparam logic [CNT_W-1:0] FRAME_FINAL = CNT_W'(FRAME_SEGS - 1);
	localparam logic [CNT_W-1:0] BYTE_END = CNT_W'(mrfe_pkg::SEGS_PER_BYTE);
	localparam logic [CNT_W-1:0] BYTE_FINAL = CNT_W'(mrfe_pkg::SEGS_PER_BYTE - 1);
	localparam logic [CNT_W-1:0] FINISH_FINAL = CNT_W'(mrfe_pkg::SEGS_PER_BYTE + 1);

	logic [mrfe_pkg::DUR_W-1:0] half_bit_q;
	logic [mrfe_pkg::DUR_W-1:0] start_pulse_q;
	logic [mrfe_pkg::DUR_W-1:0] gap_q;
	logic [mrfe_pkg::DUR_W-1:0] finish_pulse_q;

	logic             valid_s1;
	logic             op_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [CNT_W-1:0] cnt_q;

	logic                       seg_level;
	logic [mrfe_pkg::DUR_W-1:0] seg_dur;
	logic                       seg_final;
	logic                       advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q <= mrfe_pkg::HALF_BIT_RESET;
			start_pulse_q <= mrfe_pkg::START_PULSE_RESET;
			gap_q <= mrfe_pkg::GAP_RESET;
			finish_pulse_q <= mrfe_pkg::FINISH_PULSE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mrfe_pkg::REG_HALF_BIT: half_bit_q <= cfg_data;
				mrfe_pkg::REG_START_PULSE: start_pulse_q <= cfg_data;
				mrfe_pkg::REG_GAP: gap_q <= cfg_data;
				mrfe_pkg::REG_FINISH_PULSE: finish_pulse_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		seg_level = 1'b0;
		seg_dur = half_bit_q;
		seg_final = 1'b0;
		if (op_s1 == mrfe_pkg::OP_FRAME_START) begin
			seg_final = (cnt_q == FRAME_FINAL);
			if (cnt_q < PRE_END) begin
				seg_level = mrfe_pkg::PREAMBLE_PATTERN[cnt_q[3:1]] ^ cnt_q[0];
				seg_dur = half_bit_q;
			end else if (cnt_q == PRE_END) begin
				seg_level = 1'b1;
				seg_dur = start_pulse_q;
			end else if (cnt_q == PRE_END + CNT_W'(1)) begin
				seg_level = 1'b0;
				seg_dur = start_pulse_q;
			end else begin
				seg_level = 1'b0;
				seg_dur = gap_q;
			end
		end else begin
			seg_final = last_s1 ? (cnt_q == FINISH_FINAL) : (cnt_q == BYTE_FINAL);
			if (cnt_q < BYTE_END) begin
				seg_level = byte_s1[cnt_q[3:1]] ^ cnt_q[0];
				seg_dur = half_bit_q;
			end else begin
				seg_level = (cnt_q == BYTE_END);
				seg_dur = finish_pulse_q;
			end
		end
	end

	assign advance = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || (advance && seg_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q <= '0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
			cnt_q <= '0;
		end else if (advance) begin
			valid_s1 <= !seg_final;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op;
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_level <= seg_level;
			duration_us <= seg_dur;
			run_last <= seg_final;
		end
	end

endmodule

`default_nettype wire

@@ design/mrfe_checker.sv @@
// Port-level checks for the Manchester RF frame encoder.
// Uses mrfe_pkg for widths; bound to manchester_rf_frame_encoder_unit.
`default_nettype none

module mrfe_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic                             line_level,
	input wire logic [mrfe_pkg::DUR_W-1:0]       duration_us,
	input wire logic                             run_last,
	input wire logic                             cfg_valid,
	input wire logic                             cfg_ready
);

	// A stalled segment must hold its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_level)
			&& $stable(duration_us) && $stable(run_last))
		else $error("output segment changed while stalled");

	// The first segment of an accepted request shows after the expansion stage and the output register.
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("accepted request produced no segment");

	// A request's segments follow one another without a bubble.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("segment run broken before its final segment");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind manchester_rf_frame_encoder_unit mrfe_checker u_mrfe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.line_level(line_level),
	.duration_us(duration_us),
	.run_last(run_last),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

`default_nettype wire

@@ bench/manchester_rf_frame_encoder_unit_test.sv @@
// Self-checking testbench for manchester_rf_frame_encoder_unit.
// Predicts the line segments of every accepted request and checks them in order.
// Depends on mrfe_pkg and the encoder top level.
`default_nettype none

module manchester_rf_frame_encoder_unit_test;

	localparam int PREAMBLE_BYTES = 3;
	localparam int SETTLE_CYCLES = 4;
	localparam int CHOKE_CYCLES = 300;
	localparam int PHASE_REQUESTS = 36;
	localparam int TIME_LIMIT = 4000000;

	typedef logic [mrfe_pkg::DUR_W-1:0] dur_t;
	typedef logic [mrfe_pkg::CFG_INDEX_W-1:0] idx_t;

	typedef struct {
		logic             op;
		logic [7:0]       data_byte;
		logic             last_byte;
		int unsigned      idle;
	} request_t;

	typedef struct {
		logic             line_level;
		dur_t             duration_us;
		logic             run_last;
	} segment_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   op = mrfe_pkg::OP_FRAME_START;
	logic [7:0]             data_byte = 8'd0;
	logic                   last_byte = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   line_level;
	dur_t                   duration_us;
	logic                   run_last;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	idx_t                   cfg_index = mrfe_pkg::REG_HALF_BIT;
	dur_t                   cfg_data = '0;

	dur_t half_bit_cfg = mrfe_pkg::HALF_BIT_RESET;
	dur_t start_pulse_cfg = mrfe_pkg::START_PULSE_RESET;
	dur_t gap_cfg = mrfe_pkg::GAP_RESET;
	dur_t finish_pulse_cfg = mrfe_pkg::FINISH_PULSE_RESET;

	request_t    tx_requests[$];
	segment_t    expected_segs[$];
	request_t    taken_req;
	request_t    next_req;
	segment_t    want_seg;
	int unsigned hold_cycles;
	int unsigned stall_cycles;
	int unsigned segment_errors = 0;
	int unsigned segments_seen = 0;
	bit          no_idle = 1'b0;
	logic        choke_armed = 1'b0;
	int unsigned choke_count = 0;
	wire         choking = choke_armed && (choke_count < CHOKE_CYCLES);

	manchester_rf_frame_encoder_unit #(
		.PREAMBLE_BYTES(PREAMBLE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line_level(line_level),
		.duration_us(duration_us),
		.run_last(run_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIME_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void flag_mismatch(string what);
		segment_errors++;
		if (segment_errors <= 10)
			$display("mismatch: %s", what);
	endfunction

	function automatic void push_segment(logic level, dur_t dur);
		segment_t s;
		s.line_level = level;
		s.duration_us = dur;
		s.run_last = 1'b0;
		expected_segs.push_back(s);
	endfunction

	// Manchester halves, least significant bit first: a one is high then low.
	function automatic void push_byte_halves(logic [7:0] b);
		for (int i = 0; i < mrfe_pkg::BITS_PER_BYTE; i++) begin
			push_segment(b[i], half_bit_cfg);
			push_segment(!b[i], half_bit_cfg);
		end
	endfunction

	function automatic void expand_request(request_t r);
		if (r.op == mrfe_pkg::OP_FRAME_START) begin
			for (int p = 0; p < PREAMBLE_BYTES; p++)
				push_byte_halves(mrfe_pkg::PREAMBLE_PATTERN);
			push_segment(1'b1, start_pulse_cfg);
			push_segment(1'b0, start_pulse_cfg);
			push_segment(1'b0, gap_cfg);
		end else begin
			push_byte_halves(r.data_byte);
			if (r.last_byte) begin
				push_segment(1'b1, finish_pulse_cfg);
				push_segment(1'b0, finish_pulse_cfg);
			end
		end
		expected_segs[expected_segs.size()-1].run_last = 1'b1;
	endfunction

	function automatic void push_req(logic o, logic [7:0] b, logic l);
		request_t r;
		r.op = o;
		r.data_byte = b;
		r.last_byte = l;
		r.idle = no_idle ? 0 : $urandom_range(0, 6);
		tx_requests.push_back(r);
	endfunction

	function automatic dur_t pick_duration(int unsigned lo);
		case ($urandom_range(0, 3))
			0: return dur_t'(lo);
			1: return 16'hFFFF;
			default: return dur_t'($urandom_range(lo, 65535));
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= mrfe_pkg::OP_FRAME_START;
			data_byte <= 8'd0;
			last_byte <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (in_valid && in_ready) begin
				taken_req.op = op;
				taken_req.data_byte = data_byte;
				taken_req.last_byte = last_byte;
				taken_req.idle = 0;
				expand_request(taken_req);
			end
			if (!in_valid || in_ready) begin
				if (tx_requests.size() != 0 && hold_cycles >= tx_requests[0].idle) begin
					next_req = tx_requests.pop_front();
					in_valid <= 1'b1;
					op <= next_req.op;
					data_byte <= next_req.data_byte;
					last_byte <= next_req.last_byte;
					hold_cycles = 0;
				end else begin
					in_valid <= 1'b0;
					if (tx_requests.size() != 0)
						hold_cycles++;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			choke_count <= 0;
		else if (choking)
			choke_count <= choke_count + 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cycles = 0;
		end else begin
			if (out_valid && out_ready) begin
				segments_seen++;
				if (expected_segs.size() == 0) begin
					flag_mismatch($sformatf("segment %0d (level %0b dur %0d last %0b) not expected",
						segments_seen, line_level, duration_us, run_last));
				end else begin
					want_seg = expected_segs.pop_front();
					if (line_level !== want_seg.line_level || duration_us !== want_seg.duration_us ||
							run_last !== want_seg.run_last)
						flag_mismatch($sformatf(
							"segment %0d expected level %0b dur %0d last %0b, got %0b %0d %0b",
							segments_seen, want_seg.line_level, want_seg.duration_us,
							want_seg.run_last, line_level, duration_us, run_last));
				end
				stall_cycles = no_idle ? 0 : $urandom_range(0, 6);
			end
			if (choking) begin
				out_ready <= 1'b0;
			end else if (stall_cycles != 0) begin
				stall_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input idx_t idx, input dur_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			mrfe_pkg::REG_HALF_BIT: half_bit_cfg = val;
			mrfe_pkg::REG_START_PULSE: start_pulse_cfg = val;
			mrfe_pkg::REG_GAP: gap_cfg = val;
			mrfe_pkg::REG_FINISH_PULSE: finish_pulse_cfg = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Writes to an index above the register file must leave every duration alone.
	task automatic configure(input dur_t half_bit, input dur_t start_pulse,
			input dur_t gap, input dur_t finish_pulse);
		write_reg(mrfe_pkg::REG_HALF_BIT, half_bit);
		write_reg(mrfe_pkg::REG_START_PULSE, start_pulse);
		write_reg(mrfe_pkg::REG_GAP, gap);
		write_reg(mrfe_pkg::REG_FINISH_PULSE, finish_pulse);
		write_reg(idx_t'($urandom_range(4, 15)), dur_t'($urandom_range(0, 65535)));
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (tx_requests.size() != 0 || in_valid || expected_segs.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed frames with random bytes, plus stray requests and frames
	// that lack their start or their closing byte.
	task automatic queue_random_traffic(input int unsigned count);
		int unsigned made;
		int unsigned bytes;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 9) == 0) begin
				push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				made++;
			end else begin
				bytes = $urandom_range(1, 5);
				if ($urandom_range(0, 7) != 0) begin
					push_req(mrfe_pkg::OP_FRAME_START, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
					made++;
				end
				for (int i = 0; i < bytes; i++) begin
					push_req(mrfe_pkg::OP_DATA, 8'($urandom_range(0, 255)),
						(i == bytes - 1) && ($urandom_range(0, 7) != 0));
					made++;
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		push_req(mrfe_pkg::OP_DATA, 8'h5A, 1'b0);
		push_req(mrfe_pkg::OP_FRAME_START, 8'hFF, 1'b1);
		push_req(mrfe_pkg::OP_DATA, 8'h00, 1'b0);
		push_req(mrfe_pkg::OP_DATA, 8'hFF, 1'b0);
		push_req(mrfe_pkg::OP_DATA, 8'h01, 1'b0);
		push_req(mrfe_pkg::OP_DATA, 8'h80, 1'b0);
		push_req(mrfe_pkg::OP_DATA, 8'hA5, 1'b1);
		push_req(mrfe_pkg::OP_FRAME_START, 8'h00, 1'b0);
		push_req(mrfe_pkg::OP_DATA, 8'h3C, 1'b1);
		wait_drained();

		configure(16'd1, 16'd1, 16'd0, 16'd1);
		write_reg(4'd15, 16'hFFFF);
		push_req(mrfe_pkg::OP_FRAME_START, 8'h00, 1'b0);
		push_req(mrfe_pkg::OP_DATA, 8'h96, 1'b1);
		wait_drained();

		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_req(mrfe_pkg::OP_FRAME_START, 8'h7E, 1'b0);
		push_req(mrfe_pkg::OP_DATA, 8'hFF, 1'b1);
		push_req(mrfe_pkg::OP_DATA, 8'h00, 1'b1);
		wait_drained();

		configure(pick_duration(1), pick_duration(1), pick_duration(0), pick_duration(1));
		queue_random_traffic(PHASE_REQUESTS);
		wait_drained();

		no_idle = 1'b1;
		configure(pick_duration(1), pick_duration(1), pick_duration(0), pick_duration(1));
		queue_random_traffic(PHASE_REQUESTS);
		wait_drained();
		no_idle = 1'b0;

		configure(pick_duration(1), pick_duration(1), pick_duration(0), pick_duration(1));
		@(posedge clk);
		choke_armed <= 1'b1;
		queue_random_traffic(PHASE_REQUESTS);
		wait_drained();

		configure(mrfe_pkg::HALF_BIT_RESET, mrfe_pkg::START_PULSE_RESET, mrfe_pkg::GAP_RESET,
			mrfe_pkg::FINISH_PULSE_RESET);
		queue_random_traffic(PHASE_REQUESTS / 2);
		wait_drained();
		queue_random_traffic(PHASE_REQUESTS / 2);
		wait_drained();

		if (segment_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
design/mrfe_pkg.sv
design/manchester_rf_frame_encoder_unit.sv
design/mrfe_checker.sv
bench/manchester_rf_frame_encoder_unit_test.sv
